FILE: rtl/sqm_pkg.sv
// ----------------------------------------------------------------------------
// sqm_pkg
// Shared types and codes for the square matrix add/subtract/multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package sqm_pkg;

   localparam logic [1:0] KIND_LOAD_A  = 2'd0;
   localparam logic [1:0] KIND_LOAD_B  = 2'd1;
   localparam logic [1:0] KIND_COMPUTE = 2'd2;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         row_index;
      logic [1:0]         col_index;
      logic signed [31:0] element_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         out_row;
      logic [1:0]         out_col;
      logic signed [31:0] out_value;
      logic               last_result;
   } rsp_type;

   // one read issued to the datapath
   typedef struct packed {
      logic       valid;
      logic       first_k;
      logic       last_k;
      logic       last_elem;
      logic [1:0] op;
      logic [1:0] row;
      logic [1:0] col;
   } tag_type;

   typedef struct packed {
      logic we_a;
      logic we_b;
   } wr_type;

endpackage

`default_nettype wire

FILE: rtl/square_matrix_add_sub_mul.sv
// ----------------------------------------------------------------------------
// square_matrix_add_sub_mul
// Stores two SIZE x SIZE matrices and emits their sum, difference or product.
//
// Request channel (req_valid/req_ready/req_data): kind load A or load B writes
// one element at row_index/col_index; a load outside the matrix or kind 3 is
// dropped. A compute request streams SIZE*SIZE results on the response channel
// (rsp_valid/rsp_ready/rsp_data) in row-major order, last_result on the final.
// The operation register (csr_valid/csr_ready/csr_wdata) selects add, subtract
// or multiply; it is to be written by the user only while the block is idle,
// which the block does not itself enforce. A compute holds the request
// channel until its last read is issued. While the result register is not
// stalled, each cycle one read of each store feeds an add/subtract or a single
// 32x32 multiply-accumulate. Reads pass the read, value and result registers.
// A stalled result register freezes the whole read pipeline; no result is lost.
// Reset clears the operation register (add) and the control state; the stores
// are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_add_sub_mul
   import sqm_pkg::*;
#(
   parameter int SIZE = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_wdata
);

   localparam int IDXW = $clog2(SIZE);
   localparam int AW   = $clog2(SIZE * SIZE);
   localparam logic [IDXW-1:0] LAST = IDXW'(SIZE - 1);

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   state_type       state_ff;
   logic [IDXW-1:0] i_ff, j_ff, k_ff;
   logic [1:0]      operation_ff;

   logic            adv;
   logic            req_fire;
   logic            in_range;
   logic            is_mul;
   logic            last_k;
   wr_type          wr;
   logic [AW-1:0]   wr_addr;
   tag_type         tag;
   logic [AW-1:0]   rd_addr_a, rd_addr_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   assign in_range = (32'(req_data.row_index) < SIZE) && (32'(req_data.col_index) < SIZE);
   assign wr.we_a  = req_fire && in_range && (req_data.kind == KIND_LOAD_A);
   assign wr.we_b  = req_fire && in_range && (req_data.kind == KIND_LOAD_B);
   assign wr_addr  = AW'(req_data.row_index) * AW'(SIZE) + AW'(req_data.col_index);

   assign is_mul = (operation_ff == OP_MUL);
   assign last_k = !is_mul || (k_ff == LAST);

   always_comb begin
      tag.valid     = (state_ff == ST_RUN);
      tag.first_k   = !is_mul || (k_ff == '0);
      tag.last_k    = last_k;
      tag.last_elem = (i_ff == LAST) && (j_ff == LAST);
      tag.op        = operation_ff;
      tag.row       = 2'(i_ff);
      tag.col       = 2'(j_ff);
      rd_addr_a     = AW'(i_ff) * AW'(SIZE) + AW'(is_mul ? k_ff : j_ff);
      rd_addr_b     = AW'(is_mul ? k_ff : i_ff) * AW'(SIZE) + AW'(j_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         operation_ff <= OP_ADD;
      end else begin
         if (csr_valid && csr_ready) begin
            operation_ff <= csr_wdata;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_data.kind == KIND_COMPUTE) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (adv) begin
                  if (last_k) begin
                     k_ff <= '0;
                     if (j_ff == LAST) begin
                        j_ff <= '0;
                        if (i_ff == LAST) begin
                           i_ff     <= '0;
                           state_ff <= ST_IDLE;
                        end else begin
                           i_ff <= i_ff + 1'b1;
                        end
                     end else begin
                        j_ff <= j_ff + 1'b1;
                     end
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   sqm_datapath #(
      .SIZE(SIZE)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.element_value),
      .tag       (tag),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .adv       (adv),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/sqm_datapath.sv
// ----------------------------------------------------------------------------
// sqm_datapath
// Matrix stores, read/compute/accumulate pipeline and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqm_datapath
   import sqm_pkg::*;
#(
   parameter int SIZE = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wr_type                            wr,
   input  wire logic [$clog2(SIZE*SIZE)-1:0]      wr_addr,
   input  wire logic [31:0]                       wr_data,
   input  wire tag_type                           tag,
   input  wire logic [$clog2(SIZE*SIZE)-1:0]      rd_addr_a,
   input  wire logic [$clog2(SIZE*SIZE)-1:0]      rd_addr_b,
   output logic                                   adv,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output rsp_type                                rsp_data
);

   localparam int CELLS = SIZE * SIZE;

   logic [31:0] mem_a [CELLS];
   logic [31:0] mem_b [CELLS];

   logic [31:0] rd_a_ff, rd_b_ff;
   tag_type     tag1_ff, tag1_in;
   tag_type     tag2_ff, tag2_in;
   logic [31:0] val2_ff, val2_in;
   logic [31:0] acc_ff;
   logic [31:0] sum;
   logic [31:0] prod;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   assign adv = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (wr.we_a) begin
         mem_a[wr_addr] <= wr_data;
      end
      if (wr.we_b) begin
         mem_b[wr_addr] <= wr_data;
      end
      if (adv) begin
         rd_a_ff <= mem_a[rd_addr_a];
         rd_b_ff <= mem_b[rd_addr_b];
      end
   end

   assign prod = rd_a_ff * rd_b_ff;

   always_comb begin
      tag1_in = tag;
      tag2_in = tag1_ff;
      unique case (tag1_ff.op)
         OP_ADD:  val2_in = rd_a_ff + rd_b_ff;
         OP_SUB:  val2_in = rd_a_ff - rd_b_ff;
         OP_MUL:  val2_in = prod;
         default: val2_in = '0;
      endcase
      sum          = tag2_ff.first_k ? val2_ff : acc_ff + val2_ff;
      rsp_valid_in = tag2_ff.valid && tag2_ff.last_k;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         tag1_ff      <= tag1_in;
         tag2_ff      <= tag2_in;
         rsp_valid_ff <= rsp_valid_in;
         val2_ff      <= val2_in;
         if (tag2_ff.valid && !tag2_ff.last_k) begin
            acc_ff <= sum;
         end
         if (rsp_valid_in) begin
            rsp_ff.out_row     <= tag2_ff.row;
            rsp_ff.out_col     <= tag2_ff.col;
            rsp_ff.out_value   <= sum;
            rsp_ff.last_result <= tag2_ff.last_elem;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/sqm_checker.sv
// ----------------------------------------------------------------------------
// sqm_checker
// Port-level checks for square_matrix_add_sub_mul, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sqm_checker
   import sqm_pkg::*;
#(
   parameter int SIZE = 3
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response valid or request blocked after reset");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_result |->
         rsp_data.out_row == 2'(SIZE - 1) && rsp_data.out_col == 2'(SIZE - 1))
      else $error("last result not at the final element");

endmodule

bind square_matrix_add_sub_mul sqm_checker #(.SIZE(SIZE)) u_sqm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
